// ===== design/rvm_pkg.sv =====
// Shared constants and types for the resampling voice mixer.
package rvm_pkg;

    // Fixed-point format and ring geometry
    localparam int FRAC_BITS    = 12;
    localparam int RING_SAMPLES = 512;
    localparam int RING_FRAMES  = RING_SAMPLES / 2;
    localparam int RING_AW      = $clog2(RING_FRAMES);

    // State widths
    localparam int POS_W   = 40;
    localparam int FRAME_W = 28;
    localparam int CLIP_W  = 24;
    localparam int GAIN_W  = 16;
    localparam int SAMP_W  = 16;
    localparam int MIX_W   = 32;
    localparam int CMD_W   = 3;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 24;

    // Datapath product widths
    localparam int IP_W = SAMP_W + 2 + FRAC_BITS;   // (b - a) * frac
    localparam int SC_W = SAMP_W + GAIN_W + 1;      // sample * channel gain
    localparam int MP_W = MIX_W + GAIN_W + 1;       // mix * master gain

    // Output clip bounds
    localparam int SAMPLE_MIN = -32768;
    localparam int SAMPLE_MAX = 32767;

    // Refill margin in frames
    localparam int REFILL_MARGIN = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RENDER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_LEFT_GAIN   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_RIGHT_GAIN  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_STEP_RATE   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_LOOP_ENABLE = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CLIP_LENGTH = 3'd4;
    localparam logic [CFG_IW-1:0] REG_MASTER_GAIN = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic [GAIN_W-1:0] STEP_RESET = 16'd4096;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 24'd1;

    // Voice play state
    typedef enum logic [1:0] {
        PS_STOPPED = 2'd0,
        PS_PLAYING = 2'd1,
        PS_PAUSED  = 2'd2
    } play_t;

    // Item sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCALE,
        S_MIX,
        S_MASTER,
        S_CLIP,
        S_OUT
    } fsm_t;

endpackage

// ===== design/resampling_voice_mixer.sv =====
// Top level of the resampling voice mixer: one stereo playback voice.
//
// Input items arrive on in_valid/in_ready with cmd, a stereo source frame
// and the partial mix sums of earlier voices; each item gives exactly one
// result on out_valid/out_ready. Push items store a frame in the sample
// ring, play/pause/stop set the play state, render items read and
// interpolate the frame at the play position, scale it by the channel gains,
// add it to the mix sums and apply master gain with 16-bit clipping.
// The user writes registers through cfg_we/cfg_index/cfg_data only while
// idle; the block does not enforce it.
// Sequence: the item sequencer takes each accepted item through ring read
// (left and right rings, two read ports each), interpolation multiply, gain
// multiply, mix add, master multiply and clip, each a registered step, then
// holds the result valid; only one item is in flight at a time.
// Reset: voice stopped, rewind armed, registers at their defaults; the
// ring holds no valid data and needs no clearing pass.
// Stall: a finished result holds in the output registers until taken, and
// no new item is accepted meanwhile.
module resampling_voice_mixer
    import rvm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [SAMP_W-1:0] sample_left,
    input  logic signed [SAMP_W-1:0] sample_right,
    input  logic signed [MIX_W-1:0]  mix_in_left,
    input  logic signed [MIX_W-1:0]  mix_in_right,
    // output channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [MIX_W-1:0]  mix_out_left,
    output logic signed [MIX_W-1:0]  mix_out_right,
    output logic signed [SAMP_W-1:0] out_left,
    output logic signed [SAMP_W-1:0] out_right,
    output logic                     playing,
    output logic                     refill_request,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data
);

    // Configuration registers
    logic [GAIN_W-1:0] left_gain_reg;
    logic [GAIN_W-1:0] right_gain_reg;
    logic [GAIN_W-1:0] step_rate_reg;
    logic              loop_enable_reg;
    logic [CLIP_W-1:0] clip_length_reg;
    logic [GAIN_W-1:0] master_gain_reg;

    // Voice state
    logic [POS_W-1:0]   pos_reg, pos_next, pos_cur;
    logic [FRAME_W-1:0] end_reg, end_next, end_cur;
    logic [FRAME_W-1:0] ff_reg, ff_next, ff_cur;
    play_t              ps_reg, ps_next;
    logic               rewind_reg, rewind_next;

    // Sequencer
    fsm_t state_reg, state_next;
    logic in_accept;

    // Item decode
    logic                 rewind_now;
    logic [FRAME_W-1:0]   frame;
    logic [RING_AW-1:0]   frame_addr;
    logic                 unity;
    logic                 render;
    logic                 ring_we;
    logic [FRAC_BITS-1:0] frac;
    logic                 refill;

    // Per-item registers
    logic                    render_reg;
    logic [FRAC_BITS-1:0]    frac_reg;
    logic                    playing_reg;
    logic                    refill_reg;
    logic signed [MIX_W-1:0] mix_l_reg, mix_r_reg;

    // Ring read data
    logic [SAMP_W-1:0] ring_a_l, ring_b_l, ring_a_r, ring_b_r;

    // Datapath
    logic signed [SAMP_W:0]   diff_l, diff_r;
    logic signed [IP_W-1:0]   ip_l_reg, ip_r_reg;
    logic signed [SAMP_W:0]   s_l, s_r;
    logic signed [SC_W-1:0]   sc_l_reg, sc_r_reg;
    logic signed [MP_W-1:0]   mp_l_reg, mp_r_reg;
    logic signed [MP_W-1:0]   sh_l, sh_r;
    logic signed [SAMP_W-1:0] out_l_reg, out_r_reg;

    assign in_accept = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_gain_reg   <= GAIN_RESET;
            right_gain_reg  <= GAIN_RESET;
            step_rate_reg   <= STEP_RESET;
            loop_enable_reg <= 1'b0;
            clip_length_reg <= CLIP_RESET;
            master_gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_GAIN:   left_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_RIGHT_GAIN:  right_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_STEP_RATE:   step_rate_reg   <= cfg_data[GAIN_W-1:0];
                REG_LOOP_ENABLE: loop_enable_reg <= cfg_data[0];
                REG_CLIP_LENGTH: clip_length_reg <= cfg_data[CLIP_W-1:0];
                REG_MASTER_GAIN: master_gain_reg <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the accepted item and work out the next voice state
    always_comb
    begin
        rewind_now  = in_accept && (cmd == CMD_PUSH || cmd == CMD_RENDER) && rewind_reg;
        pos_cur     = rewind_now ? '0 : pos_reg;
        end_cur     = rewind_now ? FRAME_W'(clip_length_reg) : end_reg;
        ff_cur      = rewind_now ? '0 : ff_reg;
        rewind_next = rewind_now ? 1'b0 : rewind_reg;
        frame       = FRAME_W'(pos_cur >> FRAC_BITS);
        frame_addr  = frame[RING_AW-1:0];
        unity       = ({1'b0, step_rate_reg} == (GAIN_W + 1)'(1 << FRAC_BITS));
        frac        = unity ? '0 : pos_cur[FRAC_BITS-1:0];
        pos_next    = pos_cur;
        end_next    = end_cur;
        ff_next     = ff_cur;
        ps_next     = ps_reg;
        render      = 1'b0;
        ring_we     = 1'b0;
        if (in_accept)
        begin
            unique case (cmd)
                CMD_PUSH:
                begin
                    ring_we = 1'b1;
                    ff_next = ff_cur + FRAME_W'(1);
                end
                CMD_RENDER:
                begin
                    render = (ps_reg == PS_PLAYING);
                    if (render && frame >= end_cur)
                    begin
                        end_next = frame + FRAME_W'(clip_length_reg);
                        if (!loop_enable_reg)
                        begin
                            ps_next = PS_STOPPED;
                            render  = 1'b0;
                        end
                    end
                    if (render)
                    begin
                        pos_next = pos_cur + (unity ? (POS_W'(1) << FRAC_BITS)
                                                    : POS_W'(step_rate_reg));
                    end
                end
                CMD_PLAY:  ps_next = PS_PLAYING;
                CMD_PAUSE: ps_next = PS_PAUSED;
                CMD_STOP:
                begin
                    ps_next     = PS_STOPPED;
                    rewind_next = 1'b1;
                end
                default: ;
            endcase
        end
        refill = ({1'b0, frame} + (FRAME_W + 1)'(REFILL_MARGIN)) >= {1'b0, ff_next};
    end

    // Voice state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            end_reg    <= '0;
            ff_reg     <= '0;
            ps_reg     <= PS_STOPPED;
            rewind_reg <= 1'b1;
        end
        else
        begin
            pos_reg    <= pos_next;
            end_reg    <= end_next;
            ff_reg     <= ff_next;
            ps_reg     <= ps_next;
            rewind_reg <= rewind_next;
        end
    end

    // Sample rings, one per channel, frame addressed
    rvm_ram #(
        .WIDTH(SAMP_W),
        .DEPTH(RING_FRAMES)
    ) u_ring_left (
        .clk       (clk),
        .wr_en     (ring_we),
        .wr_addr   (ff_cur[RING_AW-1:0]),
        .wr_data   (sample_left),
        .rd_en     (in_accept),
        .rd_addr_a (frame_addr),
        .rd_addr_b (frame_addr + RING_AW'(1)),
        .rd_data_a (ring_a_l),
        .rd_data_b (ring_b_l)
    );

    rvm_ram #(
        .WIDTH(SAMP_W),
        .DEPTH(RING_FRAMES)
    ) u_ring_right (
        .clk       (clk),
        .wr_en     (ring_we),
        .wr_addr   (ff_cur[RING_AW-1:0]),
        .wr_data   (sample_right),
        .rd_en     (in_accept),
        .rd_addr_a (frame_addr),
        .rd_addr_b (frame_addr + RING_AW'(1)),
        .rd_data_a (ring_a_r),
        .rd_data_b (ring_b_r)
    );

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:   state_next = S_SCALE;
            S_SCALE:  state_next = S_MIX;
            S_MIX:    state_next = S_MASTER;
            S_MASTER: state_next = S_CLIP;
            S_CLIP:   state_next = S_OUT;
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Combinational steps of the datapath
    always_comb
    begin
        diff_l = $signed({ring_b_l[SAMP_W-1], ring_b_l}) - $signed({ring_a_l[SAMP_W-1], ring_a_l});
        diff_r = $signed({ring_b_r[SAMP_W-1], ring_b_r}) - $signed({ring_a_r[SAMP_W-1], ring_a_r});
        s_l    = $signed({ring_a_l[SAMP_W-1], ring_a_l}) + (SAMP_W + 1)'(ip_l_reg >>> FRAC_BITS);
        s_r    = $signed({ring_a_r[SAMP_W-1], ring_a_r}) + (SAMP_W + 1)'(ip_r_reg >>> FRAC_BITS);
        sh_l   = mp_l_reg >>> FRAC_BITS;
        sh_r   = mp_r_reg >>> FRAC_BITS;
    end

    // Latch item fields at accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            render_reg  <= render;
            frac_reg    <= frac;
            playing_reg <= (ps_next == PS_PLAYING);
            refill_reg  <= refill;
        end
    end

    // Interpolate, scale, mix, apply master gain and clip, one step a state
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mix_l_reg <= mix_in_left;
            mix_r_reg <= mix_in_right;
        end
        else if (state_reg == S_MIX && render_reg)
        begin
            mix_l_reg <= mix_l_reg + MIX_W'(sc_l_reg >>> FRAC_BITS);
            mix_r_reg <= mix_r_reg + MIX_W'(sc_r_reg >>> FRAC_BITS);
        end
        if (state_reg == S_READ)
        begin
            // Ignore the next frame when the position sits on a whole frame
            if (frac_reg == '0)
            begin
                ip_l_reg <= '0;
                ip_r_reg <= '0;
            end
            else
            begin
                ip_l_reg <= diff_l * $signed({1'b0, frac_reg});
                ip_r_reg <= diff_r * $signed({1'b0, frac_reg});
            end
        end
        if (state_reg == S_SCALE)
        begin
            sc_l_reg <= $signed(s_l[SAMP_W-1:0]) * $signed({1'b0, left_gain_reg});
            sc_r_reg <= $signed(s_r[SAMP_W-1:0]) * $signed({1'b0, right_gain_reg});
        end
        if (state_reg == S_MASTER)
        begin
            mp_l_reg <= mix_l_reg * $signed({1'b0, master_gain_reg});
            mp_r_reg <= mix_r_reg * $signed({1'b0, master_gain_reg});
        end
        if (state_reg == S_CLIP)
        begin
            if (sh_l < MP_W'(SAMPLE_MIN))
                out_l_reg <= SAMP_W'(SAMPLE_MIN);
            else if (sh_l > MP_W'(SAMPLE_MAX))
                out_l_reg <= SAMP_W'(SAMPLE_MAX);
            else
                out_l_reg <= sh_l[SAMP_W-1:0];
            if (sh_r < MP_W'(SAMPLE_MIN))
                out_r_reg <= SAMP_W'(SAMPLE_MIN);
            else if (sh_r > MP_W'(SAMPLE_MAX))
                out_r_reg <= SAMP_W'(SAMPLE_MAX);
            else
                out_r_reg <= sh_r[SAMP_W-1:0];
        end
    end

    // Drive the result
    assign mix_out_left   = mix_l_reg;
    assign mix_out_right  = mix_r_reg;
    assign out_left       = out_l_reg;
    assign out_right      = out_r_reg;
    assign playing        = playing_reg;
    assign refill_request = refill_reg;

    // A push item advances the fill count by one frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_PUSH) |=> ff_reg == $past(ff_cur) + FRAME_W'(1))
        else $error("fill count did not advance on push");

    // A render while not playing, with no rewind armed, leaves the position alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_RENDER && ps_reg != PS_PLAYING && !rewind_reg)
        |=> $stable(pos_reg))
        else $error("position moved while not playing");

    // A stop item stops the voice and arms a rewind
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_STOP) |=> (rewind_reg && ps_reg == PS_STOPPED))
        else $error("stop did not arm rewind");

    // An accepted item drops in_ready and is later followed by out_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready ##5 out_valid)
        else $error("item sequencing broken");

endmodule

// ===== design/rvm_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module rvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports, data held until the next enabled read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== dv/resampling_voice_mixer_checker.sv =====
// Checker for the resampling voice mixer: predicts every result and compares it.
`timescale 1ns / 100ps
module resampling_voice_mixer_checker
    import rvm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [SAMP_W-1:0] sample_left,
    input  logic signed [SAMP_W-1:0] sample_right,
    input  logic signed [MIX_W-1:0]  mix_in_left,
    input  logic signed [MIX_W-1:0]  mix_in_right,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [MIX_W-1:0]  mix_out_left,
    input  logic signed [MIX_W-1:0]  mix_out_right,
    input  logic signed [SAMP_W-1:0] out_left,
    input  logic signed [SAMP_W-1:0] out_right,
    input  logic                     playing,
    input  logic                     refill_request,
    input  logic                     cfg_we,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,
    output int                       mismatches,
    output int                       results_due
);

    localparam int RING_IW = $clog2(RING_SAMPLES);
    localparam logic [GAIN_W-1:0] UNITY_RATE = GAIN_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic [MIX_W-1:0]  mix_l;
        logic [MIX_W-1:0]  mix_r;
        logic [SAMP_W-1:0] out_l;
        logic [SAMP_W-1:0] out_r;
        logic              playing;
        logic              refill;
    } voice_result_t;

    // Voice state as the block should hold it
    logic signed [SAMP_W-1:0] ring_copy [RING_SAMPLES];
    logic [POS_W-1:0]         position;
    logic [FRAME_W-1:0]       end_frame;
    logic [FRAME_W-1:0]       frames_pushed;
    play_t                    voice_state;
    logic                     rewind_armed;

    // Register copies
    logic [GAIN_W-1:0] gain_l, gain_r, gain_master, rate;
    logic              loop_on;
    logic [CLIP_W-1:0] clip_len;

    voice_result_t results_q [$];
    int            fails = 0;

    // Multiply by a fixed-point gain, floor the fraction away
    function automatic longint gain_scale(input longint v, input longint g);
        return (v * g) >>> FRAC_BITS;
    endfunction

    // Linear interpolation between two frames at a fixed-point fraction
    function automatic longint lerp(input longint a, input longint b, input longint frac);
        return a + (((b - a) * frac) >>> FRAC_BITS);
    endfunction

    function automatic logic [SAMP_W-1:0] saturate(input longint v);
        if (v < SAMPLE_MIN)
            return SAMP_W'(SAMPLE_MIN);
        if (v > SAMPLE_MAX)
            return SAMP_W'(SAMPLE_MAX);
        return SAMP_W'(v);
    endfunction

    // Advance the voice by one item and queue the result it must give
    task automatic predict_voice_item(
        input logic [CMD_W-1:0]  c,
        input logic [SAMP_W-1:0] sl,
        input logic [SAMP_W-1:0] sr,
        input logic [MIX_W-1:0]  ml,
        input logic [MIX_W-1:0]  mr
    );
        logic [FRAME_W-1:0] frame;
        logic [RING_IW-1:0] i0, i1, i2, i3;
        logic               render;
        longint             lv, rv, frac;
        logic [MIX_W-1:0]   sum_l, sum_r;
        voice_result_t      r;

        sum_l = ml;
        sum_r = mr;

        // Perform a pending rewind on the next push or render
        if ((c == CMD_PUSH || c == CMD_RENDER) && rewind_armed) begin
            position      = '0;
            end_frame     = FRAME_W'(clip_len);
            frames_pushed = '0;
            rewind_armed  = 1'b0;
        end

        frame = position[POS_W-1:FRAC_BITS];

        case (c)
            CMD_PUSH:
            begin
                i0 = RING_IW'({frames_pushed, 1'b0});
                i1 = i0 + 1'b1;
                ring_copy[i0] = sl;
                ring_copy[i1] = sr;
                frames_pushed = frames_pushed + 1'b1;
            end
            CMD_RENDER:
            begin
                render = (voice_state == PS_PLAYING);
                // Clip end: set the next end, stop unless looping
                if (render && frame >= end_frame) begin
                    end_frame = frame + FRAME_W'(clip_len);
                    if (!loop_on) begin
                        voice_state = PS_STOPPED;
                        render      = 1'b0;
                    end
                end
                if (render) begin
                    i0 = RING_IW'({frame, 1'b0});
                    i1 = i0 + 1'b1;
                    i2 = i0 + 2'd2;
                    i3 = i0 + 2'd3;
                    if (rate == UNITY_RATE) begin
                        lv = ring_copy[i0];
                        rv = ring_copy[i1];
                        position = position + (POS_W'(1) << FRAC_BITS);
                    end else begin
                        frac = position[FRAC_BITS-1:0];
                        lv = lerp(ring_copy[i0], ring_copy[i2], frac);
                        rv = lerp(ring_copy[i1], ring_copy[i3], frac);
                        position = position + rate;
                    end
                    sum_l = ml + MIX_W'(gain_scale(lv, gain_l));
                    sum_r = mr + MIX_W'(gain_scale(rv, gain_r));
                end
            end
            CMD_PLAY:  voice_state = PS_PLAYING;
            CMD_PAUSE: voice_state = PS_PAUSED;
            CMD_STOP:
            begin
                voice_state  = PS_STOPPED;
                rewind_armed = 1'b1;
            end
            default: ;
        endcase

        r.mix_l   = sum_l;
        r.mix_r   = sum_r;
        r.out_l   = saturate(gain_scale(longint'($signed(sum_l)), gain_master));
        r.out_r   = saturate(gain_scale(longint'($signed(sum_r)), gain_master));
        r.playing = (voice_state == PS_PLAYING);
        r.refill  = (longint'(frame) + REFILL_MARGIN >= longint'(frames_pushed));
        results_q.push_back(r);
    endtask

    // Watch config writes and both channels
    always @(posedge clk) begin : watch
        voice_result_t got, want;
        if (!rst_n) begin
            foreach (ring_copy[i])
                ring_copy[i] = '0;
            position      = '0;
            end_frame     = '0;
            frames_pushed = '0;
            voice_state   = PS_STOPPED;
            rewind_armed  = 1'b1;
            gain_l        = GAIN_RESET;
            gain_r        = GAIN_RESET;
            rate          = STEP_RESET;
            loop_on       = 1'b0;
            clip_len      = CLIP_RESET;
            gain_master   = GAIN_RESET;
            results_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LEFT_GAIN:   gain_l      = cfg_data[GAIN_W-1:0];
                    REG_RIGHT_GAIN:  gain_r      = cfg_data[GAIN_W-1:0];
                    REG_STEP_RATE:   rate        = cfg_data[GAIN_W-1:0];
                    REG_LOOP_ENABLE: loop_on     = cfg_data[0];
                    REG_CLIP_LENGTH: clip_len    = cfg_data[CLIP_W-1:0];
                    REG_MASTER_GAIN: gain_master = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // Compare a taken result against the oldest expectation
            if (out_valid && out_ready) begin
                got = {mix_out_left, mix_out_right, out_left, out_right,
                       playing, refill_request};
                if (results_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result with nothing expected: mix %h %h out %h %h",
                                 $realtime, got.mix_l, got.mix_r, got.out_l, got.out_r);
                    fails++;
                end else begin
                    want = results_q.pop_front();
                    if (got !== want) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch: expected mix %h %h out %h %h play %b refill %b",
                                     $realtime, want.mix_l, want.mix_r, want.out_l, want.out_r,
                                     want.playing, want.refill);
                            $display("%0t:           actual   mix %h %h out %h %h play %b refill %b",
                                     $realtime, got.mix_l, got.mix_r, got.out_l, got.out_r,
                                     got.playing, got.refill);
                        end
                        fails++;
                    end
                end
            end

            if (in_valid && in_ready)
                predict_voice_item(cmd, sample_left, sample_right, mix_in_left, mix_in_right);
        end
        results_due <= results_q.size();
        mismatches  <= fails;
    end

endmodule

// ===== dv/resampling_voice_mixer_tb.sv =====
// Testbench top for the resampling voice mixer: drives items and gives the verdict.
`timescale 1ns / 100ps
module resampling_voice_mixer_tb;
    import rvm_pkg::*;

    localparam int TIMEOUT_NS    = 4_000_000;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SESSIONS      = 10;
    localparam int SESSION_ITEMS = 13;

    localparam logic [CFG_DW-1:0] UNITY_STEP = CFG_DW'(1) << FRAC_BITS;
    localparam logic [CFG_DW-1:0] HALF_STEP  = UNITY_STEP >> 1;
    localparam logic [CFG_DW-1:0] GAIN_MAX   = CFG_DW'(16'hFFFF);
    localparam logic [CFG_DW-1:0] CLIP_MAX   = CFG_DW'(24'hFF_FFFF);
    localparam logic [CFG_IW-1:0] REG_ORDER [6] = '{REG_LEFT_GAIN, REG_RIGHT_GAIN,
        REG_STEP_RATE, REG_LOOP_ENABLE, REG_CLIP_LENGTH, REG_MASTER_GAIN};

    localparam logic [SAMP_W-1:0] S_MAX = 16'h7FFF;
    localparam logic [SAMP_W-1:0] S_MIN = 16'h8000;
    localparam logic [MIX_W-1:0]  M_MAX = 32'h7FFF_FFFF;
    localparam logic [MIX_W-1:0]  M_MIN = 32'h8000_0000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [CMD_W-1:0]         cmd = CMD_PUSH;
    logic signed [SAMP_W-1:0] sample_left = '0;
    logic signed [SAMP_W-1:0] sample_right = '0;
    logic signed [MIX_W-1:0]  mix_in_left = '0;
    logic signed [MIX_W-1:0]  mix_in_right = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [MIX_W-1:0]  mix_out_left;
    logic signed [MIX_W-1:0]  mix_out_right;
    logic signed [SAMP_W-1:0] out_left;
    logic signed [SAMP_W-1:0] out_right;
    logic                     playing;
    logic                     refill_request;
    logic                     cfg_we = 1'b0;
    logic [CFG_IW-1:0]        cfg_index = REG_LEFT_GAIN;
    logic [CFG_DW-1:0]        cfg_data = '0;

    int mismatches;
    int results_due;
    int tx_idle_pct = 26;
    int rx_idle_pct = 46;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    always #10 clk = ~clk;

    resampling_voice_mixer u_dut (.*);

    resampling_voice_mixer_checker u_checker (.*);

    // Take results at random, or hold off for a long stretch on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [SAMP_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return S_MAX;
            1: return S_MIN;
            default: return SAMP_W'($urandom());
        endcase
    endfunction

    function automatic logic [MIX_W-1:0] rand_mix();
        case ($urandom_range(9))
            0: return M_MAX;
            1: return M_MIN;
            2, 3: return $urandom();
            4: return '0;
            default: return MIX_W'($urandom_range(400000)) - MIX_W'(200000);
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] rand_gain();
        case ($urandom_range(9))
            0: return '0;
            1: return GAIN_MAX;
            default: return CFG_DW'($urandom_range(8192));
        endcase
    endfunction

    // Offer one item after a random gap; return at the edge that takes it
    task automatic send_item(
        input logic [CMD_W-1:0]  c,
        input logic [SAMP_W-1:0] sl,
        input logic [SAMP_W-1:0] sr,
        input logic [MIX_W-1:0]  ml,
        input logic [MIX_W-1:0]  mr
    );
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        sample_left  <= sl;
        sample_right <= sr;
        mix_in_left  <= ml;
        mix_in_right <= mr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
    endtask

    // Write all six registers, one per cycle, while the block is idle
    task automatic write_regs(
        input logic [CFG_DW-1:0] lg,
        input logic [CFG_DW-1:0] rg,
        input logic [CFG_DW-1:0] sr,
        input logic [CFG_DW-1:0] le,
        input logic [CFG_DW-1:0] cl,
        input logic [CFG_DW-1:0] mg
    );
        logic [CFG_DW-1:0] vals [6];
        vals = '{lg, rg, sr, le, cl, mg};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CMD_W-1:0]  c;
        logic [CFG_DW-1:0] step;
        int                pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole ring once so no later read hits an unwritten entry
        repeat (RING_FRAMES)
            send_item(CMD_PUSH, rand_sample(), rand_sample(), rand_mix(), rand_mix());

        // Directed: unity rate, extreme gains, clip end without loop
        wait_results();
        write_regs(GAIN_MAX, '0, UNITY_STEP, '0, CFG_DW'(3), GAIN_MAX);
        send_item(CMD_STOP + CMD_W'(1), '0, '0, M_MAX, M_MIN);
        send_item(CMD_STOP + CMD_W'(3), '0, '0, '0, '1);
        send_item(CMD_RENDER, '0, '0, 32'd100, 32'd200);
        send_item(CMD_STOP, '0, '0, '0, '0);
        send_item(CMD_PUSH, S_MAX, S_MIN, '0, '0);
        send_item(CMD_PUSH, S_MIN, S_MAX, '0, '0);
        send_item(CMD_PUSH, '0, '0, '0, '0);
        send_item(CMD_PUSH, 16'd1, 16'hFFFF, '0, '0);
        send_item(CMD_PLAY, '0, '0, '0, '0);
        send_item(CMD_RENDER, '0, '0, M_MAX, M_MIN);
        send_item(CMD_RENDER, '0, '0, '0, '0);
        send_item(CMD_RENDER, '0, '0, M_MIN, M_MAX);
        send_item(CMD_RENDER, '0, '0, '0, '0);
        send_item(CMD_PLAY, '0, '0, '0, '0);
        send_item(CMD_RENDER, '0, '0, '0, '0);
        send_item(CMD_PAUSE, '0, '0, '0, '0);
        send_item(CMD_RENDER, '0, '0, '0, '0);

        // Directed: half-rate interpolation across extremes, looping clip
        wait_results();
        write_regs(CFG_DW'(GAIN_RESET), GAIN_MAX, HALF_STEP, CFG_DW'(1), CFG_DW'(2), '0);
        send_item(CMD_STOP, '0, '0, '0, '0);
        send_item(CMD_PUSH, S_MAX, S_MIN, '0, '0);
        send_item(CMD_PUSH, S_MIN, S_MAX, '0, '0);
        send_item(CMD_PUSH, S_MAX, S_MIN, '0, '0);
        send_item(CMD_PLAY, '0, '0, '0, '0);
        repeat (5)
            send_item(CMD_RENDER, '0, '0, '0, '0);

        // Random sessions: fresh settings, a few pushes, then play traffic
        for (int s = 0; s < SESSIONS; s++) begin
            if (s == SESSIONS / 3) begin
                tx_idle_pct <= 46;
                rx_idle_pct <= 26;
            end else if (s == 2 * SESSIONS / 3) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end

            wait_results();
            if (s == 0) begin
                write_regs('0, '0, CFG_DW'(1), '0, CFG_DW'(1), '0);
            end else if (s == 1) begin
                write_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, CFG_DW'(1), CLIP_MAX, GAIN_MAX);
            end else begin
                case ($urandom_range(3))
                    0: step = UNITY_STEP;
                    1: step = CFG_DW'($urandom_range(UNITY_STEP, 1));
                    2: step = CFG_DW'($urandom_range(3 * UNITY_STEP, UNITY_STEP));
                    default: step = CFG_DW'($urandom_range(16'hFFFF, 1));
                endcase
                write_regs(rand_gain(), rand_gain(), step, CFG_DW'($urandom_range(1)),
                           ($urandom_range(7) == 0) ? CFG_DW'($urandom_range(CLIP_MAX, 1))
                                                    : CFG_DW'($urandom_range(40, 1)),
                           rand_gain());
            end

            send_item(CMD_STOP, rand_sample(), rand_sample(), rand_mix(), rand_mix());
            repeat ($urandom_range(24, 1))
                send_item(CMD_PUSH, rand_sample(), rand_sample(), rand_mix(), rand_mix());
            send_item(CMD_PLAY, rand_sample(), rand_sample(), rand_mix(), rand_mix());

            for (int k = 0; k < SESSION_ITEMS; k++) begin
                // Long receiver hold-off while the sender keeps offering items
                if (s == 6 && k == 10)
                    hold_requests <= hold_requests + 1;
                // Sender pause until the block has drained
                if (s == 8 && k == 10)
                    wait_results();

                pick = $urandom_range(99);
                if (pick < 60)
                    c = CMD_RENDER;
                else if (pick < 72)
                    c = CMD_PUSH;
                else if (pick < 78)
                    c = CMD_PAUSE;
                else if (pick < 86)
                    c = CMD_PLAY;
                else if (pick < 90)
                    c = CMD_STOP;
                else
                    c = CMD_STOP + CMD_W'($urandom_range(3, 1));   // unused codes
                send_item(c, rand_sample(), rand_sample(), rand_mix(), rand_mix());
            end
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
